// ----- rtl/tafsm_pkg.sv -----
// Package with shared constants, types and the arctangent table of the tilt filter.
package tafsm_pkg;

    localparam int WindowDepth = 10;
    localparam int CordicSteps = 16;
    localparam int AngleFracBits = 8;
    localparam int TableFrac = 22;
    localparam int StepW = $clog2(CordicSteps + 1);
    localparam int WinIdxW = $clog2(WindowDepth);
    localparam int FillW = $clog2(WindowDepth + 1);

    // Datapath word: 17-bit corrected axis times 256 is 25 bits; CORDIC gain
    // below 1.65 and the sqrt(2) of two axes need 2 more, plus headroom.
    localparam int DataW = 30;
    localparam int AngW = 32;

    localparam logic [1:0] RegOffsetX = 2'd0;
    localparam logic [1:0] RegOffsetY = 2'd1;
    localparam logic [1:0] RegOffsetZ = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MAG   = 7'b0000010,
        ST_ANG   = 7'b0000100,
        ST_ROUND = 7'b0001000,
        ST_AVG   = 7'b0010000,
        ST_FINAL = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;
        logic mag_step;
        logic ang_prep;
        logic ang_step;
        logic round_store;
        logic avg_start;
        logic avg_step;
        logic finish;
        logic [StepW-1:0] step;
        logic [WinIdxW-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic fill_done;
    } status_t;

    function automatic logic signed [AngW-1:0] atan_entry(input logic [StepW-1:0] i);
        logic signed [AngW-1:0] r;
        begin
            case (i)
                5'd0: r = 32'sd188743680;
                5'd1: r = 32'sd111421900;
                5'd2: r = 32'sd58872272;
                5'd3: r = 32'sd29884485;
                5'd4: r = 32'sd15000234;
                5'd5: r = 32'sd7507429;
                5'd6: r = 32'sd3754631;
                5'd7: r = 32'sd1877430;
                5'd8: r = 32'sd938729;
                5'd9: r = 32'sd469366;
                5'd10: r = 32'sd234683;
                5'd11: r = 32'sd117342;
                5'd12: r = 32'sd58671;
                5'd13: r = 32'sd29335;
                5'd14: r = 32'sd14668;
                5'd15: r = 32'sd7334;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/tafsm_ctrl.sv -----
// Controller state machine sequencing the CORDIC passes and the window average.
module tafsm_ctrl
    import tafsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    out_taken,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    result_valid
);

    state_t state_reg, state_next;
    logic [StepW-1:0] step_reg, step_next;
    logic [WinIdxW-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                cmd.mag_step = 1'b1;
                if (step_reg == StepW'(CordicSteps - 1))
                begin
                    step_next  = '0;
                    state_next = ST_ANG;
                    cmd.ang_prep = 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ANG:
            begin
                cmd.ang_step = 1'b1;
                if (step_reg == StepW'(CordicSteps - 1))
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                cmd.round_store = 1'b1;
                if (status.fill_done)
                begin
                    idx_next   = WinIdxW'(1);
                    state_next = ST_AVG;
                    cmd.avg_start = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_AVG:
            begin
                cmd.avg_step = 1'b1;
                if (idx_reg == WinIdxW'(WindowDepth - 1))
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FINAL:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_taken)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && (state_reg == ST_IDLE) |=> (state_reg == ST_MAG))
        else $error("sample transaction did not start the magnitude pass");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && !out_taken |=> (state_reg == ST_OUT))
        else $error("result dropped before it was taken");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAG) || (state_reg == ST_ANG) |->
        step_reg < StepW'(CordicSteps))
        else $error("CORDIC step counter out of range");
`endif

endmodule

// ----- rtl/tafsm_datapath.sv -----
// Datapath: offset correction, shared iterative CORDIC, angle window and average.
module tafsm_datapath
    import tafsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic signed [11:0] off_x,
    input  logic signed [11:0] off_y,
    input  logic signed [11:0] off_z,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic signed [15:0] az,
    output status_t            status,
    output logic signed [15:0] angle_out,
    output logic [7:0]         servo_out
);

    // Two CORDIC lanes: lane A for (|x|, z), lane B for (|y|, 0); in the
    // angle pass lane A carries (m, yk) and lane B is idle.
    logic signed [DataW-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic signed [AngW-1:0]  z_reg;
    logic                    yneg_reg, zero_reg;
    logic signed [15:0]      win_reg [WindowDepth];
    logic [FillW-1:0]        fill_reg;
    logic signed [16:0]      avg_reg;
    logic signed [15:0]      angle_reg;
    logic [7:0]              servo_reg;

    logic signed [17:0] cx, cy, cz;
    logic signed [DataW-1:0] sx, sy, sz, absx, absy;
    logic signed [DataW-1:0] dxa, dya, dxb, dyb;
    logic signed [DataW-1:0] xa_mag, ya_mag, xb_mag, yb_mag;
    logic signed [AngW-1:0] zlim, zrnd;
    logic signed [15:0] new_ang;
    logic signed [17:0] sum;
    logic signed [16:0] pos;

    assign cx = 18'(ax) + 18'(off_x);
    assign cy = 18'(ay) + 18'(off_y);
    assign cz = 18'(az) + 18'(off_z);
    assign sx = {{(DataW-26){cx[17]}}, cx[17:0], 8'd0};
    assign sy = {{(DataW-26){cy[17]}}, cy[17:0], 8'd0};
    assign sz = {{(DataW-26){cz[17]}}, cz[17:0], 8'd0};
    assign absx = sx[DataW-1] ? -sx : sx;
    assign absy = sy[DataW-1] ? -sy : sy;

    assign dxa = ya_reg >>> cmd.step;
    assign dya = xa_reg >>> cmd.step;
    assign dxb = yb_reg >>> cmd.step;
    assign dyb = xb_reg >>> cmd.step;

    // One magnitude rotation of each lane; zero counts as positive.
    assign xa_mag = !ya_reg[DataW-1] ? xa_reg + dxa : xa_reg - dxa;
    assign ya_mag = !ya_reg[DataW-1] ? ya_reg - dya : ya_reg + dya;
    assign xb_mag = !yb_reg[DataW-1] ? xb_reg + dxb : xb_reg - dxb;
    assign yb_mag = !yb_reg[DataW-1] ? yb_reg - dyb : yb_reg + dyb;

    localparam logic signed [AngW-1:0] Limit = AngW'(90) <<< TableFrac;
    localparam int Sh = TableFrac - AngleFracBits;

    always_comb
    begin
        if (z_reg > Limit)
            zlim = Limit;
        else if (z_reg < -Limit)
            zlim = -Limit;
        else
            zlim = z_reg;
        zrnd = (zlim + (AngW'(1) <<< (Sh - 1))) >>> Sh;
        new_ang = zero_reg ? '0 : zrnd[15:0];
        sum = 18'(avg_reg) + 18'(win_reg[cmd.idx]);
        pos = avg_reg + 17'(90 <<< AngleFracBits);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xa_reg   <= absx;
            ya_reg   <= sz;
            xb_reg   <= absy;
            yb_reg   <= '0;
            yneg_reg <= sy[DataW-1];
            z_reg    <= '0;
        end
        else if (cmd.ang_prep)
        begin
            // Hand-over to the angle pass: the final magnitude step lands in
            // the same cycle, so the new operands are taken from the step result.
            xa_reg   <= xa_mag;
            ya_reg   <= yneg_reg ? -xb_mag : xb_mag;
            zero_reg <= (xa_mag == '0) && (xb_mag == '0);
        end
        else if (cmd.mag_step)
        begin
            xa_reg <= xa_mag;
            ya_reg <= ya_mag;
            xb_reg <= xb_mag;
            yb_reg <= yb_mag;
        end
        else if (cmd.ang_step)
        begin
            if (!ya_reg[DataW-1])
            begin
                xa_reg <= xa_reg + dxa;
                ya_reg <= ya_reg - dya;
                z_reg  <= z_reg + atan_entry(cmd.step);
            end
            else
            begin
                xa_reg <= xa_reg - dxa;
                ya_reg <= ya_reg + dya;
                z_reg  <= z_reg - atan_entry(cmd.step);
            end
        end
        if (cmd.avg_start)
            avg_reg <= 17'(win_reg[1]);
        else if (cmd.avg_step)
            avg_reg <= sum[17:1];
        if (cmd.finish)
        begin
            angle_reg <= avg_reg[15:0];
            if (pos[16])
                servo_reg <= 8'd0;
            else if ((pos >>> AngleFracBits) > 17'sd180)
                servo_reg <= 8'd180;
            else
                servo_reg <= 8'(pos >>> AngleFracBits);
        end
    end

    // Window: fill in order, then shift and append.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < WindowDepth; i++)
                win_reg[i] <= '0;
        end
        else if (cmd.round_store)
        begin
            if (fill_reg < FillW'(WindowDepth))
            begin
                win_reg[fill_reg[WinIdxW-1:0]] <= new_ang;
                fill_reg <= fill_reg + 1'b1;
            end
            else
            begin
                for (int i = 0; i < WindowDepth - 1; i++)
                    win_reg[i] <= win_reg[i+1];
                win_reg[WindowDepth-1] <= new_ang;
            end
        end
    end

    // avg_start reads win_reg[1] before the shift lands, which after the
    // shift is entry 0; the following steps then read idx 1.. of the shifted
    // window, so idx is offset: the sum uses win_reg[idx] after the shift.
    assign status.fill_done = (fill_reg == FillW'(WindowDepth));
    assign angle_out = angle_reg;
    assign servo_out = servo_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FillW'(WindowDepth))
        else $error("window fill count overran");
    a_fill_mono: assert property (@(posedge clk) disable iff (!rst_n)
        $past(status.fill_done) |-> status.fill_done)
        else $error("window fill count went back");
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.mag_step, cmd.ang_step, cmd.avg_step}) <= 1)
        else $error("conflicting datapath commands");
`endif

endmodule

// ----- rtl/tilt_angle_filter_servo_map.sv -----
// Top level of the tilt angle filter with servo mapping.
//
//  Channel   Direction  Handshake       Payload
//  in        input      in_valid/ready  action, accel_x/y/z, command_byte
//  out       output     out_valid/ready tilt_angle, servo_position, servo_enable
//  cfg       input      cfg_we          cfg_index, cfg_data
//
// A sample transaction takes a load step, 16 magnitude CORDIC steps, 16
// angle CORDIC steps and a rounding step on the one shared iterative
// CORDIC; once the window is full the averaging steps and the servo
// mapping follow, then the result waits in its register. A command
// transaction completes in the cycle it is accepted. Reset clears the window,
// the fill count and sets follow mode on. While a result waits to be taken
// no new sample is accepted.
module tilt_angle_filter_servo_map
    import tafsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic [7:0]         command_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] tilt_angle,
    output logic [7:0]         servo_position,
    output logic               servo_enable,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data
);

    logic signed [11:0] off_x_reg, off_y_reg, off_z_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic follow_reg, enable_reg;
    logic busy, start;
    cmd_t cmd;
    status_t status;

    assign in_ready = !busy;
    assign start    = in_valid && in_ready && !action;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= -12'sd4;
            off_y_reg <= -12'sd209;
            off_z_reg <= -12'sd121;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegOffsetX: off_x_reg <= cfg_data;
                RegOffsetY: off_y_reg <= cfg_data;
                RegOffsetZ: off_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Follow mode toggles on a zero command byte; the enable seen by a
    // result is captured when its sample is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_reg <= 1'b1;
            enable_reg <= 1'b1;
        end
        else if (in_valid && in_ready)
        begin
            if (action && (command_byte == 8'd0))
                follow_reg <= !follow_reg;
            if (!action)
                enable_reg <= follow_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
        end
    end

    tafsm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .out_taken    (out_ready),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (out_valid)
    );

    tafsm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .off_x     (off_x_reg),
        .off_y     (off_y_reg),
        .off_z     (off_z_reg),
        .ax        (start ? accel_x : ax_reg),
        .ay        (start ? accel_y : ay_reg),
        .az        (start ? accel_z : az_reg),
        .status    (status),
        .angle_out (tilt_angle),
        .servo_out (servo_position)
    );

    assign servo_enable = enable_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while a result waits");
    a_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action && (command_byte == 8'd0) |=>
        follow_reg != $past(follow_reg))
        else $error("follow mode did not toggle");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(tilt_angle) && $stable(servo_position))
        else $error("result changed while waiting");
`endif

endmodule

// ----- bench/tilt_angle_filter_servo_map_tb.sv -----
// Self-checking testbench for the tilt angle filter with servo mapping.
module tilt_angle_filter_servo_map_tb;
    import tafsm_pkg::*;

    // Index 3 decodes to no register, so a write to it must be ignored.
    localparam logic [1:0] RegNone = 2'd3;
    localparam logic ActSample = 1'b0;
    localparam logic ActCommand = 1'b1;
    localparam logic [7:0] CmdToggle = 8'd0;
    // Settling time for the block to finish a sample, with the averaging once the window is full.
    localparam int SettleCycles = 80;
    localparam int HoldCycles = 400;

    typedef struct {
        logic signed [15:0] angle;
        logic [7:0]         position;
        logic               enable;
    } servo_result_t;

    // Tracks the block's own state and holds the results it should produce, oldest first.
    class tilt_scoreboard;
        logic signed [11:0] offs[3];
        int                 window[WindowDepth];
        int                 filled;
        bit                 follow;
        servo_result_t      awaited[$];
        int                 errors;
        int                 samples;
        int                 commands;
        int                 results;
        longint             atan_deg[16] = '{
            188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
            3754631, 1877430, 938729, 469366, 234683, 117342,
            58671, 29335, 14668, 7334};

        function new();
            offs[RegOffsetX] = -12'sd4;
            offs[RegOffsetY] = -12'sd209;
            offs[RegOffsetZ] = -12'sd121;
            foreach (window[i]) window[i] = 0;
            filled = 0;
            follow = 1'b1;
            errors = 0;
            samples = 0;
            commands = 0;
            results = 0;
        endfunction

        function void set_offset(logic [1:0] idx, logic signed [11:0] val);
            if (idx != RegNone)
                offs[idx] = val;
        endfunction

        // Vectoring rotation towards the x axis; returns the grown magnitude.
        function longint rotate_mag(longint a, longint b);
            longint x;
            longint y;
            longint dx;
            longint dy;
            x = (a < 0) ? -a : a;
            y = b;
            for (int i = 0; i < CordicSteps; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx;
                    y -= dy;
                end else begin
                    x -= dx;
                    y += dy;
                end
            end
            return x;
        endfunction

        // Same rotation, accumulating the angle in degrees with 22 fraction bits.
        function longint rotate_angle(longint xi, longint yi);
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            x = xi;
            y = yi;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            for (int i = 0; i < CordicSteps; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx;
                    y -= dy;
                    z += atan_deg[i];
                end else begin
                    x -= dx;
                    y += dy;
                    z -= atan_deg[i];
                end
            end
            return z;
        endfunction

        function int tilt_deg(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
            longint lim;
            longint x;
            longint y;
            longint z;
            longint m;
            longint yk;
            longint ang;
            lim = longint'(90) <<< TableFrac;
            x = (longint'(ax) + offs[RegOffsetX]) * 256;
            y = (longint'(ay) + offs[RegOffsetY]) * 256;
            z = (longint'(az) + offs[RegOffsetZ]) * 256;
            m = rotate_mag(x, z);
            yk = rotate_mag(y, 0);
            if (y < 0)
                yk = -yk;
            ang = rotate_angle(m, yk);
            if (ang > lim) ang = lim;
            if (ang < -lim) ang = -lim;
            ang = (ang + (longint'(1) <<< (TableFrac - AngleFracBits - 1)))
                  >>> (TableFrac - AngleFracBits);
            return int'(ang);
        endfunction

        function void note_input(logic act, logic signed [15:0] ax, logic signed [15:0] ay,
                                 logic signed [15:0] az, logic [7:0] cmd);
            int            a;
            longint        avg;
            longint        pos;
            servo_result_t r;
            if (act == ActCommand) begin
                commands++;
                if (cmd == CmdToggle)
                    follow = !follow;
                return;
            end
            samples++;
            a = tilt_deg(ax, ay, az);
            if (filled < WindowDepth) begin
                window[filled] = a;
                filled++;
                return;
            end
            for (int i = 1; i < WindowDepth; i++)
                window[i - 1] = window[i];
            window[WindowDepth - 1] = a;
            avg = window[0];
            for (int i = 1; i < WindowDepth; i++)
                avg = (avg + window[i]) >>> 1;
            pos = ((longint'(90) <<< AngleFracBits) + avg) >>> AngleFracBits;
            if (pos < 0) pos = 0;
            if (pos > 180) pos = 180;
            r.angle = avg[15:0];
            r.position = pos[7:0];
            r.enable = follow;
            awaited.push_back(r);
        endfunction

        function void check_result(logic signed [15:0] ang, logic [7:0] pos, logic en);
            servo_result_t e;
            results++;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result angle=%0d pos=%0d en=%0b",
                             ang, pos, en);
                return;
            end
            e = awaited.pop_front();
            if (ang !== e.angle || pos !== e.position || en !== e.enable) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d: expected angle/pos/en=%0d/%0d/%0b, got %0d/%0d/%0b",
                             results, e.angle, e.position, e.enable, ang, pos, en);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               action;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [7:0]         command_byte;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] tilt_angle;
    logic [7:0]         servo_position;
    logic               servo_enable;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [11:0]        cfg_data;

    tilt_angle_filter_servo_map dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .accel_x(accel_x),
        .accel_y(accel_y),
        .accel_z(accel_z),
        .command_byte(command_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tilt_angle(tilt_angle),
        .servo_position(servo_position),
        .servo_enable(servo_enable),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    tilt_scoreboard tracker = new();

    // Idle percentages for the two sides, and the request for a long receiver hold-off.
    int send_idle;
    int recv_idle;
    bit hold_req;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The receiver decides its ready at each falling edge. A long hold-off is
    // counted here, so the sender keeps offering transactions and the block backs up.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                out_ready = 1'b0;
                repeat (HoldCycles) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready = ($urandom_range(99) >= recv_idle);
        end
    end

    // Results are sampled at the rising edge, where the block's outputs still hold
    // the values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(tilt_angle, servo_position, servo_enable);
    end

    // Offers one transaction, with a random gap before it, and returns after the
    // rising edge that accepts it. Called at a falling edge or just after one.
    task automatic offer(logic act, logic signed [15:0] ax, logic signed [15:0] ay,
                         logic signed [15:0] az, logic [7:0] cmd);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        action = act;
        accel_x = ax;
        accel_y = ay;
        accel_z = az;
        command_byte = cmd;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_input(act, ax, ay, az, cmd);
    endtask

    task automatic offer_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] az);
        offer(ActSample, ax, ay, az, 8'($urandom_range(255)));
    endtask

    // Random axis value: mostly near one g so that the angles spread widely,
    // sometimes anywhere in the full range, sometimes an extreme.
    function automatic logic signed [15:0] rand_axis();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return 16'($signed($urandom_range(9000)) - 4500);
        else if (sel < 9)
            return 16'($urandom);
        else
            return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endfunction

    // Drops valid and waits until every awaited result has come, then lets the
    // block finish any sample that yields no result.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.awaited.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic signed [11:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        tracker.set_offset(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_items(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0)
                offer(ActCommand, 16'($urandom), 16'($urandom), 16'($urandom),
                      $urandom_range(1) ? CmdToggle : 8'($urandom));
            else
                offer_sample(rand_axis(), rand_axis(), rand_axis());
        end
    endtask

    initial
    begin
        logic signed [11:0] ox;
        logic signed [11:0] oy;
        logic signed [11:0] oz;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ActSample;
        accel_x = '0;
        accel_y = '0;
        accel_z = '0;
        command_byte = '0;
        cfg_we = 1'b0;
        cfg_index = RegOffsetX;
        cfg_data = '0;
        send_idle = 32;
        recv_idle = 80;
        hold_req = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset offsets. The first ten samples only fill
        // the window. A zero vector after the offsets must give an angle of zero.
        offer_sample(16'sd4, 16'sd209, 16'sd121);
        offer_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        offer_sample(16'sh8000, 16'sh8000, 16'sh8000);
        offer_sample(16'sd0, 16'sh7fff, 16'sd0);
        offer_sample(16'sd0, 16'sh8000, 16'sd0);
        offer(ActCommand, 16'sd0, 16'sd0, 16'sd0, 8'hff);
        offer_sample(16'sd4, 16'sd209, 16'sd4217);
        offer_sample(16'sd4100, 16'sd209, 16'sd121);
        offer_sample(16'sh8000, 16'sh7fff, 16'sd0);
        offer_sample(16'sd0, 16'sd4305, 16'sd121);
        offer_sample(16'sd0, -16'sd3887, 16'sd121);
        offer_sample(16'sd4, 16'sd209, 16'sd121);
        offer(ActCommand, 16'sd0, 16'sd0, 16'sd0, CmdToggle);
        offer_sample(16'sd0, 16'sh7fff, 16'sd0);
        offer_sample(16'sd0, 16'sh8000, 16'sd0);
        offer(ActCommand, 16'sd0, 16'sd0, 16'sd0, 8'h01);
        offer_sample(16'sh7fff, 16'sd0, 16'sh8000);
        offer(ActCommand, 16'sd0, 16'sd0, 16'sd0, CmdToggle);
        offer_sample(16'sd4, 16'sd209, 16'sd121);
        offer_sample(16'sd0, 16'sd0, 16'sd0);
        random_items(180);
        drain();

        // The offsets at both extremes, at zero and random, with the unused index
        // written too. The idling pattern swaps midway and then stops altogether.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin ox = 12'sh7ff; oy = 12'sh7ff; oz = 12'sh7ff; end
                1: begin ox = 12'sh800; oy = 12'sh800; oz = 12'sh800; end
                2: begin ox = 12'sd0; oy = 12'sd0; oz = 12'sd0; end
                default: begin ox = 12'($urandom); oy = 12'($urandom); oz = 12'($urandom); end
            endcase
            if (ph == 1) begin
                send_idle = 80;
                recv_idle = 32;
            end else if (ph >= 2) begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(RegOffsetX, ox);
            write_reg(RegOffsetY, oy);
            write_reg(RegOffsetZ, oz);
            write_reg(RegNone, 12'($urandom));
            if (ph == 2)
                hold_req = 1'b1;
            random_items(200);
            drain();
        end

        $display("Covered %0d samples and %0d command transactions, checked %0d results,",
                 tracker.samples, tracker.commands, tracker.results);
        $display("across five offset settings, three idling patterns and a long output stall.");
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #(20 * 2_000_000);
        $display("ERROR: timeout with %0d results outstanding", tracker.awaited.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
